FILE: hw/rtl/ps2_mouse_cursor_tracker_top_defines.svh
// Assertion macros used by the cursor tracker top RTL.
`ifndef PS2_MOUSE_CURSOR_TRACKER_TOP_DEFINES_SVH
`define PS2_MOUSE_CURSOR_TRACKER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PS2MCT_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PS2MCT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ps2mct_pkg.sv
package ps2mct_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int CFG_DATA_W     = 10;
    localparam int CFG_IDX_W      = 2;
    localparam int DELTA_W        = 10;

    localparam int X_LIMIT_RST = 319;
    localparam int Y_LIMIT_RST = 199;
    localparam int POS_X_RST   = 160;
    localparam int POS_Y_RST   = 100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE  = 2'd0,
        CFG_X_LIMIT = 2'd1,
        CFG_Y_LIMIT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BP_FLAGS = 2'd0,
        BP_X     = 2'd1,
        BP_Y     = 2'd2
    } t_byte_pos;

    // Handshake view of the input register toward the packet logic.
    typedef struct packed {
        logic move;
        logic last_byte;
    } t_stage_ctl;

endpackage

FILE: hw/rtl/ps2mct_clamp.sv
module ps2mct_clamp #(
    parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]                   i_pos,
    input  logic signed [ps2mct_pkg::DELTA_W-1:0]   i_delta,
    input  logic [COORD_BITS-1:0]                   i_limit,
    output logic [COORD_BITS-1:0]                   o_pos
);
    localparam int SW = COORD_BITS + 2;

    logic signed [SW-1:0] sum;

    assign sum = SW'(signed'({2'b00, i_pos})) + SW'(i_delta);

    // A negative sum pins to zero; a sum past the limit pins to the limit.
    always_comb begin
        if (sum[SW-1]) begin
            o_pos = '0;
        end else if (sum[SW-2:0] > (COORD_BITS + 1)'(i_limit)) begin
            o_pos = i_limit;
        end else begin
            o_pos = sum[COORD_BITS-1:0];
        end
    end
endmodule

FILE: hw/rtl/ps2_mouse_cursor_tracker_top.sv
// PS/2 mouse packet decoder with cursor tracking.
// Input channel: one received mouse byte per item on i_rx_byte, taken at an edge where
// i_in_valid is high and o_in_stall is low. Bytes group into packets of flags, X, Y.
// Output channel: one item per completed packet while enable is set, carrying the
// clamped cursor, the signed deltas (Y inverted, down positive) and the button bits.
// An item is taken at an edge where o_out_valid is high and i_out_stall is low.
// A taken byte is held in the input register; the result of a third byte loads from
// there into the output register once the output register is free.
// Throughput: one byte per cycle while no third byte waits for the output; the add
// and clamp of both axes are combinational between the input and output registers.
// When the receiver stalls, the output holds; the input register keeps taking bytes
// that give no result, and only a third byte waits for the output to free.
// Reset (i_rst_n low, synchronous) clears both registers' valid bits, restarts packet
// framing at the flags byte, sets the cursor to 160,100, the limits to 319 and 199,
// and disables updates. Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data;
// the user must write it only while the block is idle; the block does not enforce this.
`include "ps2_mouse_cursor_tracker_top_defines.svh"

module ps2_mouse_cursor_tracker_top #(
    parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ps2mct_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ps2mct_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [7:0]                            i_rx_byte,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [COORD_BITS-1:0]                 o_cursor_x,
    output logic [COORD_BITS-1:0]                 o_cursor_y,
    output logic signed [8:0]                     o_delta_x,
    output logic signed [9:0]                     o_delta_y,
    output logic [2:0]                            o_buttons
);
    logic                         r_enable;
    logic [COORD_BITS-1:0]        r_x_limit;
    logic [COORD_BITS-1:0]        r_y_limit;

    logic                         r_in_valid;
    logic [7:0]                   r_in_byte;

    ps2mct_pkg::t_byte_pos        r_byte_pos;
    ps2mct_pkg::t_byte_pos        n_byte_pos;
    logic [7:0]                   r_flags;
    logic [7:0]                   r_x_byte;
    logic [COORD_BITS-1:0]        r_pos_x;
    logic [COORD_BITS-1:0]        r_pos_y;

    logic                         r_out_valid;
    logic signed [8:0]            r_delta_x;
    logic signed [9:0]            r_delta_y;
    logic [2:0]                   r_buttons;

    ps2mct_pkg::t_stage_ctl       stage;
    logic                         out_free;
    logic                         in_take;
    logic                         emit;
    logic signed [8:0]            dx;
    logic signed [8:0]            dy_raw;
    logic signed [9:0]            dy;
    logic [COORD_BITS-1:0]        new_x;
    logic [COORD_BITS-1:0]        new_y;

    assign out_free        = !r_out_valid || !i_out_stall;
    assign stage.last_byte = (r_byte_pos == ps2mct_pkg::BP_Y);
    // Only a packet's third byte needs room in the output register.
    assign stage.move      = r_in_valid && (out_free || !stage.last_byte);
    assign o_in_stall      = r_in_valid && !stage.move;
    assign in_take         = i_in_valid && !o_in_stall;
    assign emit            = stage.move && stage.last_byte && r_enable;

    always_comb begin
        case (r_byte_pos)
            ps2mct_pkg::BP_FLAGS: n_byte_pos = ps2mct_pkg::BP_X;
            ps2mct_pkg::BP_X:     n_byte_pos = ps2mct_pkg::BP_Y;
            ps2mct_pkg::BP_Y:     n_byte_pos = ps2mct_pkg::BP_FLAGS;
            default:              n_byte_pos = ps2mct_pkg::BP_X;
        endcase
    end

    always_comb begin
        dx     = signed'({r_flags[4], r_x_byte});
        dy_raw = signed'({r_flags[5], r_in_byte});
        dy     = -(10'(dy_raw));
    end

    ps2mct_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
        .i_pos   (r_pos_x),
        .i_delta (10'(dx)),
        .i_limit (r_x_limit),
        .o_pos   (new_x)
    );

    ps2mct_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
        .i_pos   (r_pos_y),
        .i_delta (dy),
        .i_limit (r_y_limit),
        .o_pos   (new_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_x_limit <= COORD_BITS'(ps2mct_pkg::X_LIMIT_RST);
            r_y_limit <= COORD_BITS'(ps2mct_pkg::Y_LIMIT_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ps2mct_pkg::CFG_ENABLE:  r_enable  <= i_cfg_data[0];
                ps2mct_pkg::CFG_X_LIMIT: r_x_limit <= COORD_BITS'(i_cfg_data);
                ps2mct_pkg::CFG_Y_LIMIT: r_y_limit <= COORD_BITS'(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (stage.move) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos <= ps2mct_pkg::BP_FLAGS;
            r_flags    <= '0;
            r_x_byte   <= '0;
            r_pos_x    <= COORD_BITS'(ps2mct_pkg::POS_X_RST);
            r_pos_y    <= COORD_BITS'(ps2mct_pkg::POS_Y_RST);
        end else if (stage.move) begin
            r_byte_pos <= n_byte_pos;
            if (r_byte_pos == ps2mct_pkg::BP_X) begin
                r_x_byte <= r_in_byte;
            end else if (!stage.last_byte) begin
                r_flags <= r_in_byte;
            end
            if (emit) begin
                r_pos_x <= new_x;
                r_pos_y <= new_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
        if (emit) begin
            r_delta_x <= dx;
            r_delta_y <= dy;
            r_buttons <= r_flags[2:0];
        end
    end

    // The cursor registers change only when a new result loads, so they serve as output.
    assign o_out_valid = r_out_valid;
    assign o_cursor_x  = r_pos_x;
    assign o_cursor_y  = r_pos_y;
    assign o_delta_x   = r_delta_x;
    assign o_delta_y   = r_delta_y;
    assign o_buttons   = r_buttons;

    `PS2MCT_ASSERT_SAME(a_pos_in_range, i_clk, i_rst_n, 1'b1, r_byte_pos != 2'd3, "byte position out of range")
    `PS2MCT_ASSERT_SAME(a_cursor_clamped, i_clk, i_rst_n, r_out_valid, (r_pos_x <= r_x_limit) && (r_pos_y <= r_y_limit), "cursor beyond limit")
    `PS2MCT_ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, emit, r_out_valid && (r_byte_pos == ps2mct_pkg::BP_FLAGS), "packet result missing")
    `PS2MCT_ASSERT_SAME(a_stall_only_third, i_clk, i_rst_n, o_in_stall, r_in_valid && stage.last_byte && r_out_valid, "stall without pending result")
endmodule

FILE: verif/ps2_mouse_cursor_tracker_checker.sv
`timescale 1ns / 1ps

module ps2_mouse_cursor_tracker_checker #(
    parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ps2mct_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ps2mct_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [7:0]                        i_rx_byte,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [COORD_BITS-1:0]             i_cursor_x,
    input  logic [COORD_BITS-1:0]             i_cursor_y,
    input  logic signed [8:0]                 i_delta_x,
    input  logic signed [9:0]                 i_delta_y,
    input  logic [2:0]                        i_buttons,
    output int                                o_mismatch_count,
    output int                                o_pending_reports
);
    typedef struct {
        logic [COORD_BITS-1:0] cursor_x;
        logic [COORD_BITS-1:0] cursor_y;
        logic signed [8:0]     delta_x;
        logic signed [9:0]     delta_y;
        logic [2:0]            buttons;
    } t_cursor_report;

    ps2mct_pkg::t_byte_pos pkt_pos;
    logic                  track_en;
    logic [COORD_BITS-1:0] lim_x;
    logic [COORD_BITS-1:0] lim_y;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [7:0]            flags_q;
    logic [7:0]            xbyte_q;
    t_cursor_report        cursor_reports_q[$];
    int                    mismatch_count = 0;
    int                    pending_count  = 0;

    assign o_mismatch_count  = mismatch_count;
    assign o_pending_reports = pending_count;

    function automatic logic [COORD_BITS-1:0] clamp_move(
        input logic [COORD_BITS-1:0] pos,
        input int                    delta,
        input logic [COORD_BITS-1:0] limit
    );
        int sum;
        sum = int'(pos) + delta;
        if (sum < 0)
            return '0;
        if (sum > int'(limit))
            return limit;
        return COORD_BITS'(sum);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch, %s", $time, msg);
        mismatch_count++;
    endtask

    // Advances packet framing by one byte; a completed packet moves the cursor
    // only while tracking is enabled, and only then produces a report.
    task automatic decode_mouse_byte(input logic [7:0] rx);
        logic signed [8:0] dx9;
        logic signed [8:0] dy9;
        int                dx;
        int                dy;
        t_cursor_report    rep;
        case (pkt_pos)
            ps2mct_pkg::BP_X: begin
                xbyte_q = rx;
                pkt_pos = ps2mct_pkg::BP_Y;
            end
            ps2mct_pkg::BP_Y: begin
                pkt_pos = ps2mct_pkg::BP_FLAGS;
                if (track_en) begin
                    dx9 = {flags_q[4], xbyte_q};
                    dy9 = {flags_q[5], rx};
                    dx  = dx9;
                    dy  = -dy9;
                    pos_x = clamp_move(pos_x, dx, lim_x);
                    pos_y = clamp_move(pos_y, dy, lim_y);
                    rep.cursor_x = pos_x;
                    rep.cursor_y = pos_y;
                    rep.delta_x  = dx9;
                    rep.delta_y  = 10'(dy);
                    rep.buttons  = flags_q[2:0];
                    cursor_reports_q.push_back(rep);
                end
            end
            default: begin
                flags_q = rx;
                pkt_pos = ps2mct_pkg::BP_X;
            end
        endcase
    endtask

    task automatic check_cursor_report();
        t_cursor_report want;
        want = cursor_reports_q.pop_front();
        if (i_cursor_x !== want.cursor_x)
            report_mismatch($sformatf("cursor_x got %0d, expected %0d",
                                      i_cursor_x, want.cursor_x));
        if (i_cursor_y !== want.cursor_y)
            report_mismatch($sformatf("cursor_y got %0d, expected %0d",
                                      i_cursor_y, want.cursor_y));
        if (i_delta_x !== want.delta_x)
            report_mismatch($sformatf("delta_x got %0d, expected %0d",
                                      i_delta_x, want.delta_x));
        if (i_delta_y !== want.delta_y)
            report_mismatch($sformatf("delta_y got %0d, expected %0d",
                                      i_delta_y, want.delta_y));
        if (i_buttons !== want.buttons)
            report_mismatch($sformatf("buttons got %0d, expected %0d",
                                      i_buttons, want.buttons));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pkt_pos  = ps2mct_pkg::BP_FLAGS;
            track_en = 1'b0;
            lim_x    = COORD_BITS'(ps2mct_pkg::X_LIMIT_RST);
            lim_y    = COORD_BITS'(ps2mct_pkg::Y_LIMIT_RST);
            pos_x    = COORD_BITS'(ps2mct_pkg::POS_X_RST);
            pos_y    = COORD_BITS'(ps2mct_pkg::POS_Y_RST);
            flags_q  = '0;
            xbyte_q  = '0;
            cursor_reports_q.delete();
        end else begin
            // A result leaving at this edge can never come from a byte taken at
            // the same edge, so the output side is checked first.
            if (i_out_valid && !i_out_stall) begin
                if (cursor_reports_q.size() == 0)
                    report_mismatch("result item with no expected result waiting");
                else
                    check_cursor_report();
            end
            if (i_cfg_we) begin
                case (ps2mct_pkg::t_cfg_idx'(i_cfg_idx))
                    ps2mct_pkg::CFG_ENABLE:  track_en = i_cfg_data[0];
                    ps2mct_pkg::CFG_X_LIMIT: lim_x = COORD_BITS'(i_cfg_data);
                    ps2mct_pkg::CFG_Y_LIMIT: lim_y = COORD_BITS'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                decode_mouse_byte(i_rx_byte);
        end
        pending_count = cursor_reports_q.size();
    end

endmodule

FILE: verif/ps2_mouse_cursor_tracker_top_test.sv
`timescale 1ns / 1ps

module ps2_mouse_cursor_tracker_top_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 9;
    localparam int PHASE_PKTS  = 65;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [ps2mct_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [ps2mct_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic [7:0]            rx_byte   = '0;
    logic                  out_stall = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic [ps2mct_pkg::COORD_BITS_DEF-1:0] cursor_x;
    logic [ps2mct_pkg::COORD_BITS_DEF-1:0] cursor_y;
    logic signed [8:0]     delta_x;
    logic signed [9:0]     delta_y;
    logic [2:0]            buttons;
    int                    mismatches;
    int                    pending;
    int                    send_idle_pct = 19;
    int                    recv_idle_pct = 50;
    int                    cycles = 0;

    always #1 clk = ~clk;

    ps2_mouse_cursor_tracker_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_rx_byte   (rx_byte),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_cursor_x  (cursor_x),
        .o_cursor_y  (cursor_y),
        .o_delta_x   (delta_x),
        .o_delta_y   (delta_y),
        .o_buttons   (buttons)
    );

    ps2_mouse_cursor_tracker_checker i_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_rx_byte         (rx_byte),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_cursor_x        (cursor_x),
        .i_cursor_y        (cursor_y),
        .i_delta_x         (delta_x),
        .i_delta_y         (delta_y),
        .i_buttons         (buttons),
        .o_mismatch_count  (mismatches),
        .o_pending_reports (pending)
    );

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Called and returns at a falling edge. Valid stays high after the item is
    // taken; the next call either replaces the byte or drops valid for a gap.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_packet(input logic [7:0] flags, input logic [7:0] xb,
                               input logic [7:0] yb);
        send_byte(flags);
        send_byte(xb);
        send_byte(yb);
    endtask

    // Holds the sender off until every expected cursor report has arrived, then
    // leaves time for a third byte of a disabled packet still in the pipeline.
    task automatic wait_for_reports();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input ps2mct_pkg::t_cfg_idx idx,
                             input logic [ps2mct_pkg::CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial begin
        logic                              en;
        logic [ps2mct_pkg::CFG_DATA_W-1:0] xl;
        logic [ps2mct_pkg::CFG_DATA_W-1:0] yl;
        logic [7:0]                        flags;
        logic [7:0]                        xb;
        logic [7:0]                        yb;
        int                                mag;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Tracking is off after reset, so this packet must be swallowed.
        send_packet(8'h07, 8'h10, 8'h10);
        wait_for_reports();
        write_reg(ps2mct_pkg::CFG_ENABLE, 10'd1);

        send_packet(8'h08, 8'h00, 8'h00);
        send_packet(8'h07, 8'hFF, 8'hFF);
        send_packet(8'h30, 8'h00, 8'h00);
        send_packet(8'hD1, 8'h01, 8'h80);
        send_packet(8'h22, 8'h7F, 8'h01);
        send_packet(8'h04, 8'h80, 8'h7F);
        send_packet(8'h3C, 8'hAA, 8'h55);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            en = 1'b1;
            xl = ps2mct_pkg::CFG_DATA_W'($urandom_range(1, 1023));
            yl = ps2mct_pkg::CFG_DATA_W'($urandom_range(1, 1023));
            case (ph)
                0: begin xl = 10'd319;  yl = 10'd199;  end
                1: begin xl = 10'd1023; yl = 10'd1023; end
                2: begin xl = 10'd1;    yl = 10'd1;    end
                3: begin en = 1'b0; xl = 10'd500; yl = 10'd500; end
                4: begin xl = 10'd0;    yl = 10'd0;    end
                6: begin xl = 10'd40;   yl = 10'd900;  end
                8: begin xl = 10'd1023; yl = 10'd1;    end
                default: ;
            endcase
            if (ph < 3) begin
                send_idle_pct = 19;
                recv_idle_pct = 50;
            end else if (ph < 6) begin
                send_idle_pct = 50;
                recv_idle_pct = 19;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            wait_for_reports();
            write_reg(ps2mct_pkg::CFG_ENABLE, ps2mct_pkg::CFG_DATA_W'(en));
            write_reg(ps2mct_pkg::CFG_X_LIMIT, xl);
            write_reg(ps2mct_pkg::CFG_Y_LIMIT, yl);

            for (int p = 0; p < PHASE_PKTS; p++) begin
                flags = 8'($urandom);
                if ($urandom_range(3) == 0) begin
                    xb = 8'($urandom);
                    yb = 8'($urandom);
                end else begin
                    // Small moves keep the cursor off the edges for a while.
                    mag = $urandom_range(20);
                    xb  = flags[4] ? 8'(-mag) : 8'(mag);
                    mag = $urandom_range(20);
                    yb  = flags[5] ? 8'(-mag) : 8'(mag);
                end
                send_packet(flags, xb, yb);
            end
            // A partial packet now and then straddles the next register update.
            repeat ($urandom_range(2)) send_byte(8'($urandom));
        end

        wait_for_reports();
        repeat (6) @(negedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: ps2_mouse_cursor_tracker_top.f
+incdir+hw/rtl
hw/rtl/ps2mct_pkg.sv
hw/rtl/ps2mct_clamp.sv
hw/rtl/ps2_mouse_cursor_tracker_top.sv
verif/ps2_mouse_cursor_tracker_checker.sv
verif/ps2_mouse_cursor_tracker_top_test.sv
